>>> hw/rtl/pgg_pkg.sv
// Shared types, constants and elaboration-time functions of the pixel gain and gamma core.
`default_nettype none
package pgg_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int NUM_STEPS  = 20;
  localparam int LANE_LAT   = 44;
  localparam int ADDR_W     = 5;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [23:0] GAIN_DEN   = 24'd65280;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

  typedef enum logic [1:0] {
    FMT_RGBA   = 2'd0,
    FMT_RGB    = 2'd1,
    FMT_SINGLE = 2'd2,
    FMT_NONE   = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_GAIN_RED   = 3'd0,
    REG_GAIN_GREEN = 3'd1,
    REG_GAIN_BLUE  = 3'd2,
    REG_GAMMA      = 3'd3,
    REG_PREMUL     = 3'd4,
    REG_FORMAT     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] gain_red;
    logic [15:0] gain_green;
    logic [15:0] gain_blue;
    logic [15:0] gamma;
    logic        premul;
    fmt_t        fmt;
  } cfg_t;

  // Early-out result that bypasses the log/exp datapath.
  typedef struct packed {
    logic       on;
    logic [7:0] val;
  } spec_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bv;
    n  = n_in;
    r  = 64'd0;
    bv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bv > n) bv = bv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bv != 64'd0) begin
        if (n >= r + bv) begin
          n = n - (r + bv);
          r = (r >> 1) + bv;
        end else begin
          r = r >> 1;
        end
        bv = bv >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_q20(input logic [63:0] n);
    logic [63:0] m;
    logic [63:0] res;
    int e;
    e = 0;
    for (int i = 0; i < 63; i++) begin
      if ((n >> (e + 1)) != 64'd0) e++;
    end
    m   = n << (30 - e);
    res = 64'(e) << FRAC_BITS;
    for (int k = 0; k < FRAC_BITS; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m   = m >> 1;
        res = res | (64'd1 << (FRAC_BITS - 1 - k));
      end
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30, taken as the k-fold square root of one half.
  function automatic logic [63:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'h2000_0000;
    for (int j = 1; j <= k; j++) begin
      c = isqrt64(c << 30);
    end
    return c;
  endfunction

  localparam logic [23:0] LOG2_DEN = 24'(log2_q20(64'd65280));

endpackage
`default_nettype wire

>>> hw/rtl/pgg_cfg.sv
// APB register file holding the gain, gamma, premultiply and format settings.
`default_nettype none
module pgg_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pgg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output pgg_pkg::cfg_t                   cfg
);
  import pgg_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_GAIN_RED:   cfg_nxt.gain_red   = pwdata[15:0];
        REG_GAIN_GREEN: cfg_nxt.gain_green = pwdata[15:0];
        REG_GAIN_BLUE:  cfg_nxt.gain_blue  = pwdata[15:0];
        REG_GAMMA:      cfg_nxt.gamma      = pwdata[15:0];
        REG_PREMUL:     cfg_nxt.premul     = pwdata[0];
        REG_FORMAT:     cfg_nxt.fmt        = fmt_t'(pwdata[1:0]);
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_RED:   prdata = {16'd0, cfg_r.gain_red};
      REG_GAIN_GREEN: prdata = {16'd0, cfg_r.gain_green};
      REG_GAIN_BLUE:  prdata = {16'd0, cfg_r.gain_blue};
      REG_GAMMA:      prdata = {16'd0, cfg_r.gamma};
      REG_PREMUL:     prdata = {31'd0, cfg_r.premul};
      REG_FORMAT:     prdata = {30'd0, cfg_r.fmt};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_red   <= 16'd256;
      cfg_r.gain_green <= 16'd256;
      cfg_r.gain_blue  <= 16'd256;
      cfg_r.gamma      <= 16'd4096;
      cfg_r.premul     <= 1'b0;
      cfg_r.fmt        <= FMT_RGBA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pgg_curve.sv
// One channel lane: gain, fixed-point log2, gamma product and exp2, one step per stage.
`default_nettype none
module pgg_curve (
  input  wire logic        clk,
  input  wire logic [7:0]  v,
  input  wire logic [15:0] gain,
  input  wire logic [15:0] gamma,
  output logic      [7:0]  result
);
  import pgg_pkg::*;

  logic [23:0] n_r;
  logic [30:0] m_r   [NUM_STEPS+1];
  logic [23:0] res_r [NUM_STEPS+1];
  spec_t       sqs_r [NUM_STEPS+1];
  logic [30:0] y_r   [NUM_STEPS+1];
  logic [27:0] t_r   [NUM_STEPS+1];
  spec_t       exs_r [NUM_STEPS+1];
  logic [7:0]  result_r;

  // Product of pixel and gain.
  always_ff @(posedge clk) begin
    n_r <= 24'(v) * 24'(gain);
  end

  // Special cases and normalization of the mantissa to [1,2) in Q30.
  logic [3:0]  e_lead;
  logic [45:0] shifted;
  spec_t       spec_nxt;

  always_comb begin
    e_lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (n_r[i]) e_lead = 4'(i);
    end
    shifted = 46'(n_r[15:0]) << (5'd30 - {1'b0, e_lead});
    spec_nxt.on  = 1'b0;
    spec_nxt.val = 8'd0;
    if (n_r == 24'd0) begin
      spec_nxt.on  = 1'b1;
      spec_nxt.val = (gamma == 16'd0) ? FULL_SCALE : 8'd0;
    end else if (n_r >= GAIN_DEN || gamma == 16'd0) begin
      spec_nxt.on  = 1'b1;
      spec_nxt.val = FULL_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    m_r[0]   <= shifted[30:0];
    res_r[0] <= {e_lead, 20'd0};
    sqs_r[0] <= spec_nxt;
  end

  // Log2 fraction: one squaring per stage yields one result bit.
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] sq_hi;
    assign sq    = 62'(m_r[k]) * 62'(m_r[k]);
    assign sq_hi = sq[61:30];
    always_ff @(posedge clk) begin
      sqs_r[k+1] <= sqs_r[k];
      if (sq_hi[31]) begin
        m_r[k+1]   <= sq_hi[31:1];
        res_r[k+1] <= res_r[k] | (24'd1 << (FRAC_BITS - 1 - k));
      end else begin
        m_r[k+1]   <= sq_hi[30:0];
        res_r[k+1] <= res_r[k];
      end
    end
  end

  // Exponent of the result: -log2(x) scaled by gamma.
  logic [23:0] l_dist;
  logic [39:0] lg_prod;
  assign l_dist  = LOG2_DEN - res_r[NUM_STEPS];
  assign lg_prod = 40'(l_dist) * 40'(gamma);

  always_ff @(posedge clk) begin
    t_r[0]   <= lg_prod[39:12];
    y_r[0]   <= Q30_ONE;
    exs_r[0] <= sqs_r[NUM_STEPS];
  end

  // Exp2 of the fraction: one conditional Q30 product per stage.
  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_exp
    localparam logic [29:0] COEF = 30'(exp_coef(k + 1));
    logic [60:0] prod;
    assign prod = 61'(y_r[k]) * 61'(COEF);
    always_ff @(posedge clk) begin
      t_r[k+1]   <= t_r[k];
      exs_r[k+1] <= exs_r[k];
      y_r[k+1]   <= t_r[k][FRAC_BITS - 1 - k] ? prod[60:30] : y_r[k];
    end
  end

  // Integer shift, scale to 0..255 with round half up, clamp.
  logic [7:0]  ip;
  logic [30:0] y_sh;
  logic [38:0] scaled;
  logic [8:0]  r9;
  logic [7:0]  r8;

  always_comb begin
    ip     = t_r[NUM_STEPS][27:20];
    y_sh   = y_r[NUM_STEPS] >> ip[3:0];
    scaled = 39'(y_sh) * 39'(FULL_SCALE) + 39'(Q30_ONE >> 1);
    r9     = scaled[38:30];
    r8     = (r9 > 9'(FULL_SCALE)) ? FULL_SCALE : r9[7:0];
    if (exs_r[NUM_STEPS].on) begin
      r8 = exs_r[NUM_STEPS].val;
    end else if (ip >= 8'd9) begin
      r8 = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= r8;
  end

  assign result = result_r;

endmodule
`default_nettype wire

>>> hw/rtl/pixel_gain_gamma_premultiply_core.sv
// Top level of the pixel gain, gamma and alpha premultiply core.
// Every accepted word gives its result after the 44 lane stages and the premultiply output
// stage. Throughput: one word per cycle; busy stays low.
// The rate is set by the three fully pipelined channel lanes, one log/exp step per stage.
// The result receiver cannot stall, so out_valid is a one-cycle strobe per word.
// Reset (synchronous, rst_n low) empties the valid pipeline and restores register defaults.
`default_nettype none
module pixel_gain_gamma_premultiply_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [7:0]                 in_chan0,
  input  wire logic [7:0]                 in_chan1,
  input  wire logic [7:0]                 in_chan2,
  input  wire logic [7:0]                 in_chan3,
  input  wire logic                       in_image_end,
  output logic                            out_valid,
  output logic      [7:0]                 out_chan0,
  output logic      [7:0]                 out_chan1,
  output logic      [7:0]                 out_chan2,
  output logic      [7:0]                 out_chan3,
  output logic                            out_image_end,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pgg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);
  import pgg_pkg::*;

  // Raw word and its valid bit, carried alongside the lanes.
  typedef struct packed {
    logic       vld;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    logic       img_end;
  } side_t;

  cfg_t  cfg;
  side_t side_r [LANE_LAT];
  logic  in_fire;
  logic [7:0] lane0, lane1, lane2;

  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  pgg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pgg_curve u_lane0 (
    .clk(clk), .v(in_chan0), .gain(cfg.gain_red), .gamma(cfg.gamma), .result(lane0)
  );
  pgg_curve u_lane1 (
    .clk(clk), .v(in_chan1), .gain(cfg.gain_green), .gamma(cfg.gamma), .result(lane1)
  );
  pgg_curve u_lane2 (
    .clk(clk), .v(in_chan2), .gain(cfg.gain_blue), .gamma(cfg.gamma), .result(lane2)
  );

  // Side pipeline: valid bits reset, payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) side_r[i].vld <= 1'b0;
    end else begin
      side_r[0].vld <= in_fire;
      for (int i = 1; i < LANE_LAT; i++) side_r[i].vld <= side_r[i-1].vld;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0].c0      <= in_chan0;
    side_r[0].c1      <= in_chan1;
    side_r[0].c2      <= in_chan2;
    side_r[0].c3      <= in_chan3;
    side_r[0].img_end <= in_image_end;
    for (int i = 1; i < LANE_LAT; i++) begin
      side_r[i].c0      <= side_r[i-1].c0;
      side_r[i].c1      <= side_r[i-1].c1;
      side_r[i].c2      <= side_r[i-1].c2;
      side_r[i].c3      <= side_r[i-1].c3;
      side_r[i].img_end <= side_r[i-1].img_end;
    end
  end

  // floor(p / 255) for p up to 255*255, by the reciprocal identity.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] s;
    s = p + 16'd1 + {8'd0, p[15:8]};
    return s[15:8];
  endfunction

  side_t      tail;
  logic       color3, curve0, premul_on;
  logic [7:0] c0_nxt, c1_nxt, c2_nxt;

  assign tail = side_r[LANE_LAT-1];

  // Format selects the curved channels; RGBA with premul set scales them by alpha.
  always_comb begin
    color3    = (cfg.fmt == FMT_RGBA) || (cfg.fmt == FMT_RGB);
    curve0    = color3 || (cfg.fmt == FMT_SINGLE);
    premul_on = (cfg.fmt == FMT_RGBA) && cfg.premul;
    c0_nxt = curve0 ? lane0 : tail.c0;
    c1_nxt = color3 ? lane1 : tail.c1;
    c2_nxt = color3 ? lane2 : tail.c2;
    if (premul_on) begin
      c0_nxt = div255(16'(lane0) * 16'(tail.c3));
      c1_nxt = div255(16'(lane1) * 16'(tail.c3));
      c2_nxt = div255(16'(lane2) * 16'(tail.c3));
    end
  end

  logic       out_valid_r;
  logic [7:0] out_c0_r, out_c1_r, out_c2_r, out_c3_r;
  logic       out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_c0_r  <= c0_nxt;
    out_c1_r  <= c1_nxt;
    out_c2_r  <= c2_nxt;
    out_c3_r  <= tail.c3;
    out_end_r <= tail.img_end;
  end

  assign out_valid     = out_valid_r;
  assign out_chan0     = out_c0_r;
  assign out_chan1     = out_c1_r;
  assign out_chan2     = out_c2_r;
  assign out_chan3     = out_c3_r;
  assign out_image_end = out_end_r;

`ifndef SYNTHESIS
  a_strobe_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(side_r[LANE_LAT-1].vld)))
    else $error("result strobe does not follow the valid pipeline");

  a_alpha_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chan3 == $past(side_r[LANE_LAT-1].c3)))
    else $error("alpha was altered");

  a_single_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg.fmt == FMT_SINGLE) |->
      (out_chan1 == $past(side_r[LANE_LAT-1].c1)))
    else $error("channel 1 not passed through in single-channel format");

  a_none_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg.fmt == FMT_NONE) |->
      (out_chan0 == $past(side_r[LANE_LAT-1].c0)))
    else $error("channel 0 not passed through for the unused format code");
`endif

endmodule
`default_nettype wire
